// ===== src/hsv_pkg.sv =====
package hsv_pkg;

    localparam int unsigned ChanW = 16;
    localparam int unsigned NumCells = ChanW;

    // Hue constants, 65535 stands for 360 degrees
    localparam logic [15:0] DEG60  = 16'd10922;
    localparam logic [15:0] DEG120 = 16'd21845;
    localparam logic [15:0] DEG240 = 16'd43690;
    localparam logic [15:0] DEG360 = 16'd65535;

    // Hue sector select: which channel is largest and sign of the offset
    localparam logic [2:0] SEL_RED_POS = 3'd0;
    localparam logic [2:0] SEL_RED_NEG = 3'd1;
    localparam logic [2:0] SEL_GRN_POS = 3'd2;
    localparam logic [2:0] SEL_GRN_NEG = 3'd3;
    localparam logic [2:0] SEL_BLU_POS = 3'd4;
    localparam logic [2:0] SEL_BLU_NEG = 3'd5;

    // Data handed from one divider cell to the next
    typedef struct packed {
        logic        valid;
        logic [2:0]  sel;
        logic        zero;
        logic [15:0] value;
        logic [15:0] s_div;
        logic [15:0] s_rem;
        logic [15:0] s_low;
        logic [15:0] s_quo;
        logic [15:0] h_div;
        logic [15:0] h_rem;
        logic [15:0] h_low;
        logic [15:0] h_quo;
    } cell_t;

endpackage

// ===== src/hsv_div_cell.sv =====
module hsv_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  hsv_pkg::cell_t    cell_in,
    output hsv_pkg::cell_t    cell_out
);

    hsv_pkg::cell_t cell_reg;
    hsv_pkg::cell_t cell_next;
    logic [16:0]    s_trial;
    logic [16:0]    h_trial;
    logic           s_bit;
    logic           h_bit;

    // Shift in the next dividend bit and try one subtract per divider
    always_comb
    begin
        s_trial = {cell_in.s_rem, cell_in.s_low[15]};
        h_trial = {cell_in.h_rem, cell_in.h_low[15]};
        s_bit   = (s_trial >= {1'b0, cell_in.s_div});
        h_bit   = (h_trial >= {1'b0, cell_in.h_div});
        cell_next       = cell_in;
        cell_next.s_low = {cell_in.s_low[14:0], 1'b0};
        cell_next.h_low = {cell_in.h_low[14:0], 1'b0};
        cell_next.s_quo = {cell_in.s_quo[14:0], s_bit};
        cell_next.h_quo = {cell_in.h_quo[14:0], h_bit};
        cell_next.s_rem = s_bit ? 16'(s_trial - {1'b0, cell_in.s_div}) : s_trial[15:0];
        cell_next.h_rem = h_bit ? 16'(h_trial - {1'b0, cell_in.h_div}) : h_trial[15:0];
    end

    // Advance when the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== src/rgb_to_hsv_converter_core.sv =====
// RGB to HSV converter: takes one RGB pixel of three 16-bit channels per clock
// while pixel_ready is high and returns hue, saturation and value as 16-bit
// fractions of 65535. An accepted input transaction passes through the max/min
// front-end register, a row of divider cells that each resolve one quotient bit
// of both the saturation and hue ratio divisions, the 60-degree scaling
// multiply register and the final hue adjust into the output register. The
// whole pipeline holds while the output transaction is stalled, so pixel_ready
// follows hsv_ready when the output is full.
module rgb_to_hsv_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    output logic        hsv_valid,
    input  logic        hsv_ready,
    output logic [15:0] hue_out,
    output logic [15:0] saturation_out,
    output logic [15:0] value_out
);

    logic en;

    // Front end signals
    logic [15:0] mx;
    logic [15:0] mn;
    logic [15:0] diff;
    logic [2:0]  sel;
    logic        fe_valid_reg;
    logic [15:0] fe_mx_reg;
    logic [15:0] fe_delta_reg;
    logic [15:0] fe_diff_reg;
    logic [2:0]  fe_sel_reg;

    hsv_pkg::cell_t chain [hsv_pkg::NumCells+1];

    // Multiply stage
    logic        mul_valid_reg;
    logic [2:0]  mul_sel_reg;
    logic        mul_zero_reg;
    logic [15:0] mul_value_reg;
    logic [15:0] mul_sat_reg;
    logic [29:0] mul_prod_reg;
    logic [29:0] mul_prod_next;

    // Output stage
    logic [31:0] scaled_sum;
    logic [15:0] scaled;
    logic [15:0] hue_next;
    logic        out_valid_reg;
    logic [15:0] hue_reg;
    logic [15:0] sat_reg;
    logic [15:0] value_reg;

    // Hold everything while the output is full and stalled
    assign en          = !out_valid_reg || hsv_ready;
    assign pixel_ready = en;

    // Find max, min, sector and channel difference
    always_comb
    begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        if (red_in == mx)
        begin
            sel  = (green_in >= blue_in) ? hsv_pkg::SEL_RED_POS : hsv_pkg::SEL_RED_NEG;
            diff = (green_in >= blue_in) ? 16'(green_in - blue_in) : 16'(blue_in - green_in);
        end
        else if (green_in == mx)
        begin
            sel  = (blue_in >= red_in) ? hsv_pkg::SEL_GRN_POS : hsv_pkg::SEL_GRN_NEG;
            diff = (blue_in >= red_in) ? 16'(blue_in - red_in) : 16'(red_in - blue_in);
        end
        else
        begin
            sel  = (red_in >= green_in) ? hsv_pkg::SEL_BLU_POS : hsv_pkg::SEL_BLU_NEG;
            diff = (red_in >= green_in) ? 16'(red_in - green_in) : 16'(green_in - red_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fe_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fe_mx_reg    <= mx;
            fe_delta_reg <= 16'(mx - mn);
            fe_diff_reg  <= diff;
            fe_sel_reg   <= sel;
        end
    end

    // Load the dividers with a * 65535 = (a << 16) - a
    always_comb
    begin
        chain[0].valid = fe_valid_reg;
        chain[0].sel   = fe_sel_reg;
        chain[0].zero  = (fe_delta_reg == 16'd0);
        chain[0].value = fe_mx_reg;
        chain[0].s_div = fe_mx_reg;
        chain[0].s_rem = (fe_delta_reg != 16'd0) ? 16'(fe_delta_reg - 16'd1) : 16'd0;
        chain[0].s_low = 16'(17'h10000 - {1'b0, fe_delta_reg});
        chain[0].s_quo = 16'd0;
        chain[0].h_div = fe_delta_reg;
        chain[0].h_rem = (fe_diff_reg != 16'd0) ? 16'(fe_diff_reg - 16'd1) : 16'd0;
        chain[0].h_low = 16'(17'h10000 - {1'b0, fe_diff_reg});
        chain[0].h_quo = 16'd0;
    end

    // Row of divider cells, one quotient bit each
    for (genvar i = 0; i < hsv_pkg::NumCells; i++)
    begin : g_cell
        hsv_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Scale the hue ratio by 60 degrees
    assign mul_prod_next = {14'd0, chain[hsv_pkg::NumCells].h_quo}
                         * {14'd0, hsv_pkg::DEG60};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= chain[hsv_pkg::NumCells].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_sel_reg   <= chain[hsv_pkg::NumCells].sel;
            mul_zero_reg  <= chain[hsv_pkg::NumCells].zero;
            mul_value_reg <= chain[hsv_pkg::NumCells].value;
            mul_sat_reg   <= chain[hsv_pkg::NumCells].s_quo;
            mul_prod_reg  <= mul_prod_next;
        end
    end

    // Divide by 65535: floor(x / 65535) = (x + (x >> 16) + 1) >> 16
    assign scaled_sum = {2'b0, mul_prod_reg} + 32'(mul_prod_reg[29:16]) + 32'd1;
    assign scaled     = scaled_sum[31:16];

    // Place the offset in its sector
    always_comb
    begin
        case (mul_sel_reg)
            hsv_pkg::SEL_RED_POS: hue_next = scaled;
            hsv_pkg::SEL_RED_NEG: hue_next = 16'(hsv_pkg::DEG360 - scaled);
            hsv_pkg::SEL_GRN_POS: hue_next = 16'(hsv_pkg::DEG120 + scaled);
            hsv_pkg::SEL_GRN_NEG: hue_next = 16'(hsv_pkg::DEG120 - scaled);
            hsv_pkg::SEL_BLU_POS: hue_next = 16'(hsv_pkg::DEG240 + scaled);
            hsv_pkg::SEL_BLU_NEG: hue_next = 16'(hsv_pkg::DEG240 - scaled);
            default:              hue_next = 16'd0;
        endcase
        if (mul_zero_reg)
        begin
            hue_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= mul_zero_reg ? 16'd0 : mul_sat_reg;
            value_reg <= mul_value_reg;
        end
    end

    assign hsv_valid      = out_valid_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign value_out      = value_reg;

endmodule
